@@ rtl/ctp_pkg.sv @@
`timescale 1ns / 1ps
// ctp_pkg: item types, fixed-point constants and the arctangent table
// for the cartesian_to_polar pipeline. No dependencies.

package ctp_pkg;

    localparam int FIELD_W    = 16;
    localparam int GUARD_BITS = 24;
    localparam int TABLE_LEN  = 32;
    localparam int TURN_W     = 32;

    localparam logic [TURN_W-1:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [TURN_W-1:0] ANGLE_ROUND = 32'h0000_8000;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [TURN_W-1:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
    } ctp_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] radius;
        logic [FIELD_W-1:0] angle;
    } ctp_out_t;

endpackage

@@ rtl/ctp_cordic.sv @@
`timescale 1ns / 1ps
// ctp_cordic: unrolled CORDIC vectoring pipeline that yields the angle
// and carries the item valid bits. Depends on ctp_pkg.

module ctp_cordic import ctp_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int LATENCY      = 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          out_valid,
    output logic [FIELD_W-1:0]            angle
);

    localparam int W   = COORD_WIDTH + GUARD_BITS + 3;
    localparam int PAD = LATENCY - (CORDIC_STEPS + 2);

    logic signed [W-1:0]  x_reg     [0:CORDIC_STEPS-1];
    logic signed [W-1:0]  y_reg     [0:CORDIC_STEPS-1];
    logic [TURN_W-1:0]    z_reg     [0:CORDIC_STEPS];
    logic                 zero_reg  [0:CORDIC_STEPS];
    logic                 valid_reg [0:CORDIC_STEPS];

    logic signed [W-1:0]  x_next, y_next;
    logic [TURN_W-1:0]    z_next;

    logic [FIELD_W-1:0]   angle_reg, angle_next;
    logic                 fvalid_reg;
    logic [TURN_W-1:0]    z_round;

    // pre-rotation into the right half plane, then guard shift
    always_comb begin
        x_next = W'(x_coord);
        y_next = W'(y_coord);
        z_next = '0;
        if (x_coord < 0) begin
            x_next = -x_next;
            y_next = -y_next;
            z_next = HALF_TURN;
        end
        x_next = x_next <<< GUARD_BITS;
        y_next = y_next <<< GUARD_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (x_coord == '0) && (y_coord == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [W-1:0] xs, ys;
        logic signed [W-1:0] xs_next, ys_next;
        logic [TURN_W-1:0]   zs_next;

        always_comb begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!y_reg[i][W-1]) begin
                xs_next = x_reg[i] + ys;
                ys_next = y_reg[i] - xs;
                zs_next = z_reg[i] + ATAN_TURN[i];
            end else begin
                xs_next = x_reg[i] - ys;
                ys_next = y_reg[i] + xs;
                zs_next = z_reg[i] - ATAN_TURN[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i+1]    <= zs_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        // the last step only needs the angle
        if (i < CORDIC_STEPS - 1) begin : g_xy
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i+1] <= xs_next;
                    y_reg[i+1] <= ys_next;
                end
            end
        end
    end

    // round to 16 bits of a turn; the origin reports angle zero
    always_comb begin
        z_round    = z_reg[CORDIC_STEPS] + ANGLE_ROUND;
        angle_next = zero_reg[CORDIC_STEPS] ? '0 : z_round[TURN_W-1 -: FIELD_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= 1'b0;
        end else if (en) begin
            fvalid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    // delay to line up with the radius path
    if (PAD > 0) begin : g_pad
        logic [FIELD_W-1:0] pad_angle_reg [0:PAD-1];
        logic               pad_valid_reg [0:PAD-1];

        for (genvar p = 0; p < PAD; p++) begin : g_tap
            always_ff @(posedge aclk) begin
                if (en) begin
                    pad_angle_reg[p] <= (p == 0) ? angle_reg : pad_angle_reg[(p == 0) ? 0 : p-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    pad_valid_reg[p] <= 1'b0;
                end else if (en) begin
                    pad_valid_reg[p] <= (p == 0) ? fvalid_reg
                                                 : pad_valid_reg[(p == 0) ? 0 : p-1];
                end
            end
        end

        assign angle     = pad_angle_reg[PAD-1];
        assign out_valid = pad_valid_reg[PAD-1];
    end else begin : g_nopad
        assign angle     = angle_reg;
        assign out_valid = fvalid_reg;
    end

endmodule

@@ rtl/ctp_isqrt.sv @@
`timescale 1ns / 1ps
// ctp_isqrt: squares, sum and a pipelined digit-by-digit integer square
// root that yields the saturated radius. Depends on ctp_pkg.

module ctp_isqrt import ctp_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int LATENCY     = 19
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic [FIELD_W-1:0]            radius
);

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = 2 * COORD_WIDTH;
    localparam int RW  = COORD_WIDTH + 2;
    localparam int PAD = LATENCY - (COORD_WIDTH + 3);

    logic [CW-1:0]      ax, ay;
    logic [NW-1:0]      sqx_reg, sqy_reg;
    logic [NW-1:0]      num_reg  [0:CW-1];
    logic [RW-1:0]      rem_reg  [0:CW-1];
    logic [CW-1:0]      root_reg [0:CW];
    logic [FIELD_W-1:0] rad_reg, rad_next;

    // magnitudes fit unsigned in the coordinate width
    always_comb begin
        ax = x_coord[CW-1] ? CW'(-x_coord) : CW'(x_coord);
        ay = y_coord[CW-1] ? CW'(-y_coord) : CW'(y_coord);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg     <= NW'(ax) * NW'(ax);
            sqy_reg     <= NW'(ay) * NW'(ay);
            num_reg[0]  <= sqx_reg + sqy_reg;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar j = 0; j < CW; j++) begin : g_root
        logic [RW-1:0] rem_sh, trial, rem_next;
        logic [CW-1:0] root_next;

        always_comb begin
            rem_sh = {rem_reg[j][RW-3:0], num_reg[j][NW-1 -: 2]};
            trial  = {root_reg[j], 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[j][CW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[j][CW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[j+1] <= root_next;
            end
        end

        if (j < CW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j+1] <= rem_next;
                    num_reg[j+1] <= num_reg[j] << 2;
                end
            end
        end
    end

    always_comb begin
        if ((root_reg[CW] >> FIELD_W) != '0) begin
            rad_next = '1;
        end else begin
            rad_next = FIELD_W'(root_reg[CW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= rad_next;
        end
    end

    if (PAD > 0) begin : g_pad
        logic [FIELD_W-1:0] pad_rad_reg [0:PAD-1];

        for (genvar p = 0; p < PAD; p++) begin : g_tap
            always_ff @(posedge aclk) begin
                if (en) begin
                    pad_rad_reg[p] <= (p == 0) ? rad_reg : pad_rad_reg[(p == 0) ? 0 : p-1];
                end
            end
        end

        assign radius = pad_rad_reg[PAD-1];
    end else begin : g_nopad
        assign radius = rad_reg;
    end

endmodule

@@ rtl/ctp_outbuf.sv @@
`timescale 1ns / 1ps
// ctp_outbuf: two-entry output buffer (head plus skid) that decouples the
// pipeline enable from the result channel ready. Depends on ctp_pkg.

module ctp_outbuf import ctp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  ctp_out_t in_data,
    output logic     in_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ctp_out_t m_data
);

    logic     head_valid_reg, head_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ctp_out_t head_reg, head_next;
    ctp_out_t skid_reg, skid_next;
    logic     push, pop;

    // ready comes from a register only, so there is no combinational path from m_ready
    assign in_ready = !skid_valid_reg;
    assign m_valid  = head_valid_reg;
    assign m_data   = head_reg;

    always_comb begin
        push            = in_valid && !skid_valid_reg;
        pop             = head_valid_reg && m_ready;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push && (!head_valid_reg || pop)) begin
            head_next       = in_data;
            head_valid_next = 1'b1;
        end else if (push) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

@@ rtl/cartesian_to_polar.sv @@
`timescale 1ns / 1ps
// cartesian_to_polar: top level, point in, radius and angle out.
// Depends on ctp_pkg, ctp_cordic, ctp_isqrt and ctp_outbuf.
//
//   channel | ports                      | payload
//   --------+----------------------------+--------------------------
//   input   | s_valid, s_ready, s_data   | ctp_in_t  (x_coord, y_coord)
//   result  | m_valid, m_ready, m_data   | ctp_out_t (radius, angle)
//
// One item per cycle sustained while the result channel keeps taking results. Latency is
// set by the longer of the unrolled CORDIC chain and the one-bit-per-stage root,
// plus the head register of the output buffer.
// The whole pipeline advances together while the two-entry output buffer
// has room; s_ready drops only when both entries hold results.
// Reset clears the valid bits and the buffer; payload registers are not reset.

module cartesian_to_polar import ctp_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ctp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ctp_out_t m_data
);

    localparam int LATENCY = (CORDIC_STEPS + 2 > COORD_WIDTH + 3) ?
                             CORDIC_STEPS + 2 : COORD_WIDTH + 3;

    logic                          en;
    logic signed [COORD_WIDTH-1:0] x_trim, y_trim;
    logic                          pipe_valid;
    ctp_out_t                      pipe_data;

    // bits above the coordinate width are dropped, missing ones read as zero
    assign x_trim = $signed(COORD_WIDTH'($unsigned(s_data.x_coord)));
    assign y_trim = $signed(COORD_WIDTH'($unsigned(s_data.y_coord)));

    assign s_ready = en;

    ctp_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .LATENCY      (LATENCY)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .x_coord   (x_trim),
        .y_coord   (y_trim),
        .out_valid (pipe_valid),
        .angle     (pipe_data.angle)
    );

    ctp_isqrt #(
        .COORD_WIDTH (COORD_WIDTH),
        .LATENCY     (LATENCY)
    ) u_isqrt (
        .aclk    (aclk),
        .en      (en),
        .x_coord (x_trim),
        .y_coord (y_trim),
        .radius  (pipe_data.radius)
    );

    ctp_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid),
        .in_data  (pipe_data),
        .in_ready (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/ctp_checker.sv @@
`timescale 1ns / 1ps
// ctp_checker: port-level assertions for cartesian_to_polar, attached by
// the bind at the end of this file. Depends on ctp_pkg.

module ctp_checker import ctp_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ctp_out_t m_data
);

    // a result waiting on the output holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing is shown right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is refused only while a result is waiting
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // taking a result always frees room for the next item
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready)
        else $error("input not ready after a result was taken");

    // only the origin has radius zero, and it reports angle zero
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.radius == '0) |-> (m_data.angle == '0))
        else $error("zero radius with nonzero angle");

endmodule

bind cartesian_to_polar ctp_checker u_ctp_checker (.*);
